@@ hw/rtl/mvpt_pkg.sv @@
// ----------------------------------------------------------------------------
// mvpt_pkg
// Shared types and widths for the move-point-toward-target block.
// ----------------------------------------------------------------------------
package mvpt_pkg;

    localparam int S2_W    = 66;            // exact squared length, 2^-32 units
    localparam int ROOT_W  = 49;            // distance width, Q.32
    localparam int STEP_W  = 51;            // speed * time, 2^-32 units
    localparam int NUM_W   = 32 + STEP_W;   // |d| * step
    localparam int Q_W     = 41;            // quotient bits 40..0
    localparam int SQ_REM_W = ROOT_W + 2;   // sqrt remainder
    localparam int ARR_W   = S2_W + 13;     // 6400 * s2
    localparam int MOVE_W  = Q_W + 1;       // signed move and sum

    typedef struct packed {
        logic signed [31:0] from_x;
        logic signed [31:0] from_y;
        logic signed [31:0] from_z;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] target_z;
        logic [30:0]        move_speed;
        logic [19:0]        elapsed_time;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] new_x;
        logic signed [31:0] new_y;
        logic signed [31:0] new_z;
        logic               arrived;
    } out_item_t;

    // classified job handed from front to back
    typedef struct packed {
        logic [2:0][31:0]      from;
        logic [2:0]            neg;
        logic [2:0][NUM_W-1:0] num;
        logic [S2_W-1:0]       s2;
        logic                  arrived;
        logic                  still;
    } job_t;

endpackage

@@ hw/rtl/mvpt_front.sv @@
// ----------------------------------------------------------------------------
// mvpt_front
// Accepts items, forms the difference vector, squared length, arrival test
// and the per-axis dividends. Four register stages, stalls as one.
// ----------------------------------------------------------------------------
module mvpt_front
    import mvpt_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_item,
    output logic     q_valid,
    input  logic     q_ready,
    output job_t     q_job
);

    logic adv;
    logic [3:0] v_reg;

    // stage 1 payload
    logic [2:0][31:0] f1_from_reg, f1_mag_reg;
    logic [2:0]       f1_neg_reg;
    logic [30:0]      f1_speed_reg;
    logic [19:0]      f1_time_reg;
    // stage 2 payload
    logic [2:0][31:0] f2_from_reg, f2_mag_reg;
    logic [2:0]       f2_neg_reg;
    logic [2:0][63:0] f2_sq_reg;
    logic [61:0]      f2_sp2_reg;
    logic [STEP_W-1:0] f2_step_reg;
    // stage 3 payload
    logic [2:0][31:0] f3_from_reg;
    logic [2:0]       f3_neg_reg;
    logic [S2_W-1:0]  f3_s2_reg;
    logic [61:0]      f3_sp2_reg;
    logic [2:0][63:0] f3_plo_reg;
    logic [2:0][STEP_W-1:0] f3_phi_reg;
    // stage 4 output
    job_t             job_reg;

    logic signed [32:0] d [3];
    logic signed [31:0] fr [3];
    logic signed [31:0] tg [3];
    logic [ARR_W-1:0]   s2_x;

    assign adv     = !v_reg[3] || q_ready;
    assign s_ready = adv;
    assign q_valid = v_reg[3];
    assign q_job   = job_reg;

    // difference vector
    always_comb begin
        fr[0] = s_item.from_x;   fr[1] = s_item.from_y;   fr[2] = s_item.from_z;
        tg[0] = s_item.target_x; tg[1] = s_item.target_y; tg[2] = s_item.target_z;
        for (int k = 0; k < 3; k++) begin
            d[k] = 33'(tg[k]) - 33'(fr[k]);
        end
    end

    // arrival scale, 6400 = 4096 + 2048 + 256
    assign s2_x = (ARR_W'(f3_s2_reg) << 12) + (ARR_W'(f3_s2_reg) << 11)
                + (ARR_W'(f3_s2_reg) << 8);

    // valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[2:0], s_valid};
        end
    end

    // datapath stages
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                f1_from_reg[k] <= fr[k];
                f1_neg_reg[k]  <= d[k][32];
                f1_mag_reg[k]  <= d[k][32] ? 32'(-d[k]) : d[k][31:0];
            end
            f1_speed_reg <= s_item.move_speed;
            f1_time_reg  <= s_item.elapsed_time;

            f2_from_reg <= f1_from_reg;
            f2_mag_reg  <= f1_mag_reg;
            f2_neg_reg  <= f1_neg_reg;
            for (int k = 0; k < 3; k++) begin
                f2_sq_reg[k] <= 64'(f1_mag_reg[k]) * 64'(f1_mag_reg[k]);
            end
            f2_sp2_reg  <= 62'(f1_speed_reg) * 62'(f1_speed_reg);
            f2_step_reg <= STEP_W'(f1_speed_reg) * STEP_W'(f1_time_reg);

            f3_from_reg <= f2_from_reg;
            f3_neg_reg  <= f2_neg_reg;
            f3_sp2_reg  <= f2_sp2_reg;
            f3_s2_reg   <= S2_W'(f2_sq_reg[0]) + S2_W'(f2_sq_reg[1]) + S2_W'(f2_sq_reg[2]);
            for (int k = 0; k < 3; k++) begin
                f3_plo_reg[k] <= 64'(f2_mag_reg[k]) * 64'(f2_step_reg[31:0]);
                f3_phi_reg[k] <= STEP_W'(f2_mag_reg[k])
                               * STEP_W'(f2_step_reg[STEP_W-1:32]);
            end

            job_reg.from <= f3_from_reg;
            job_reg.neg  <= f3_neg_reg;
            for (int k = 0; k < 3; k++) begin
                job_reg.num[k] <= NUM_W'(f3_plo_reg[k])
                                + (NUM_W'(f3_phi_reg[k]) << 32);
            end
            job_reg.s2      <= f3_s2_reg;
            job_reg.arrived <= s2_x < ARR_W'(f3_sp2_reg);
            job_reg.still   <= f3_s2_reg == '0;
        end
    end

endmodule

@@ hw/rtl/mvpt_queue.sv @@
// ----------------------------------------------------------------------------
// mvpt_queue
// Four-entry job queue between front and back.
// ----------------------------------------------------------------------------
module mvpt_queue
    import mvpt_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  job_t in_job,
    output logic out_valid,
    input  logic out_ready,
    output job_t out_job
);

    job_t       mem [4];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] cnt_reg;
    logic       push, pop;

    assign in_ready  = cnt_reg != 3'd4;
    assign out_valid = cnt_reg != 3'd0;
    assign out_job   = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 2'd1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 2'd1;
            cnt_reg <= cnt_reg + 3'(push) - 3'(pop);
        end
    end

endmodule

@@ hw/rtl/mvpt_back.sv @@
// ----------------------------------------------------------------------------
// mvpt_back
// Pipelined square root (one root bit per stage), pipelined restoring
// divide on three axes (one quotient bit per stage), then cap, sign, add and
// saturate into the output register.
// ----------------------------------------------------------------------------
module mvpt_back
    import mvpt_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  job_t      in_job,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    typedef struct packed {
        job_t                job;
        logic [SQ_REM_W-1:0] rem;
        logic [ROOT_W-1:0]   root;
    } sq_t;

    typedef struct packed {
        logic [2:0][31:0]        from;
        logic [2:0]              neg;
        logic [2:0][NUM_W-1:0]   num;
        logic                    arrived;
        logic                    still;
        logic [ROOT_W-1:0]       den;
        logic [2:0]              ovf;
        logic [2:0][ROOT_W-1:0]  rem;
        logic [2:0][Q_W-1:0]     q;
    } dv_t;

    logic adv;
    sq_t  sq_reg [ROOT_W+1];
    logic [ROOT_W:0] sq_v_reg;
    dv_t  dv_reg [Q_W+1];
    logic [Q_W:0] dv_v_reg;
    out_item_t out_reg;
    logic      out_v_reg;

    assign adv      = !out_v_reg || m_ready;
    assign in_ready = adv;
    assign m_valid  = out_v_reg;
    assign m_item   = out_reg;

    // valid chain through both pipelines
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_v_reg  <= '0;
            dv_v_reg  <= '0;
            out_v_reg <= 1'b0;
        end else if (adv) begin
            sq_v_reg  <= {sq_v_reg[ROOT_W-1:0], in_valid};
            dv_v_reg  <= {dv_v_reg[Q_W-1:0], sq_v_reg[ROOT_W]};
            out_v_reg <= dv_v_reg[Q_W];
        end
    end

    // sqrt entry
    always_ff @(posedge aclk) begin
        if (adv) begin
            sq_reg[0].job  <= in_job;
            sq_reg[0].rem  <= '0;
            sq_reg[0].root <= '0;
        end
    end

    // sqrt stages, radicand is s2 * 2^32
    for (genvar i = 0; i < ROOT_W; i++) begin : g_sq
        localparam int J = ROOT_W - 1 - i;
        logic [2*ROOT_W-1:0] rad;
        logic [SQ_REM_W+1:0] wide, trial;
        logic                take;
        assign rad   = {sq_reg[i].job.s2, 32'b0};
        assign wide  = {sq_reg[i].rem, rad[2*J+1], rad[2*J]};
        assign trial = {2'b0, sq_reg[i].root, 2'b01};
        assign take  = wide >= trial;
        always_ff @(posedge aclk) begin
            if (adv) begin
                sq_reg[i+1].job  <= sq_reg[i].job;
                sq_reg[i+1].rem  <= take ? SQ_REM_W'(wide - trial) : SQ_REM_W'(wide);
                sq_reg[i+1].root <= {sq_reg[i].root[ROOT_W-2:0], take};
            end
        end
    end

    // divide entry: range check for quotient at or above 2^41
    always_ff @(posedge aclk) begin
        if (adv) begin
            dv_reg[0].from    <= sq_reg[ROOT_W].job.from;
            dv_reg[0].neg     <= sq_reg[ROOT_W].job.neg;
            dv_reg[0].num     <= sq_reg[ROOT_W].job.num;
            dv_reg[0].arrived <= sq_reg[ROOT_W].job.arrived;
            dv_reg[0].still   <= sq_reg[ROOT_W].job.still;
            dv_reg[0].den     <= sq_reg[ROOT_W].root;
            for (int k = 0; k < 3; k++) begin
                dv_reg[0].ovf[k] <= ROOT_W'(sq_reg[ROOT_W].job.num[k][NUM_W-1:Q_W])
                                  >= sq_reg[ROOT_W].root;
                dv_reg[0].rem[k] <= ROOT_W'(sq_reg[ROOT_W].job.num[k][NUM_W-1:Q_W]);
                dv_reg[0].q[k]   <= '0;
            end
        end
    end

    // divide stages, quotient bit Q_W-1-i
    for (genvar i = 0; i < Q_W; i++) begin : g_dv
        localparam int B = Q_W - 1 - i;
        logic [2:0][ROOT_W:0] wide;
        logic [2:0]           take;
        always_comb begin
            for (int k = 0; k < 3; k++) begin
                wide[k] = {dv_reg[i].rem[k], dv_reg[i].num[k][B]};
                take[k] = wide[k] >= {1'b0, dv_reg[i].den};
            end
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                dv_reg[i+1].from    <= dv_reg[i].from;
                dv_reg[i+1].neg     <= dv_reg[i].neg;
                dv_reg[i+1].num     <= dv_reg[i].num;
                dv_reg[i+1].arrived <= dv_reg[i].arrived;
                dv_reg[i+1].still   <= dv_reg[i].still;
                dv_reg[i+1].den     <= dv_reg[i].den;
                dv_reg[i+1].ovf     <= dv_reg[i].ovf;
                for (int k = 0; k < 3; k++) begin
                    dv_reg[i+1].rem[k] <= take[k]
                        ? ROOT_W'(wide[k] - {1'b0, dv_reg[i].den})
                        : ROOT_W'(wide[k]);
                    dv_reg[i+1].q[k] <= {dv_reg[i].q[k][Q_W-2:0], take[k]};
                end
            end
        end
    end

    // cap, sign, add and saturate
    logic [2:0][Q_W-1:0]      mcap;
    logic signed [MOVE_W-1:0] sum [3];
    logic [2:0][31:0]         res;
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (dv_reg[Q_W].ovf[k] || dv_reg[Q_W].q[k] > (Q_W'(1) << (Q_W-1))) begin
                mcap[k] = Q_W'(1) << (Q_W-1);
            end else begin
                mcap[k] = dv_reg[Q_W].q[k];
            end
            sum[k] = MOVE_W'(signed'(dv_reg[Q_W].from[k]))
                   + (dv_reg[Q_W].neg[k] ? -MOVE_W'(mcap[k]) : MOVE_W'(mcap[k]));
            if (dv_reg[Q_W].arrived || dv_reg[Q_W].still) begin
                res[k] = dv_reg[Q_W].from[k];
            end else if (sum[k] > MOVE_W'(signed'(32'sh7fffffff))) begin
                res[k] = 32'h7fffffff;
            end else if (sum[k] < MOVE_W'(signed'(32'sh80000000))) begin
                res[k] = 32'h80000000;
            end else begin
                res[k] = sum[k][31:0];
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (adv) begin
            out_reg.new_x   <= res[0];
            out_reg.new_y   <= res[1];
            out_reg.new_z   <= res[2];
            out_reg.arrived <= dv_reg[Q_W].arrived;
        end
    end

endmodule

@@ hw/rtl/move_point_toward_target.sv @@
// ----------------------------------------------------------------------------
// move_point_toward_target
// Path through 4 front stages, the queue register, 1 root entry stage,
// 49 root stages, 1 range-check stage, 41 quotient stages and the output
// register.
// Throughput one item per cycle while m_ready is high; pipelined root, divide.
// Reset (aresetn low, synchronous) empties all stages and the queue.
// ----------------------------------------------------------------------------
module move_point_toward_target
    import mvpt_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    logic fq_valid, fq_ready, qb_valid, qb_ready;
    job_t fq_job, qb_job;

    // classify
    mvpt_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .q_valid (fq_valid),
        .q_ready (fq_ready),
        .q_job   (fq_job)
    );

    // decouple
    mvpt_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_job    (fq_job),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_job   (qb_job)
    );

    // root, divide, move
    mvpt_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (qb_valid),
        .in_ready (qb_ready),
        .in_job   (qb_job),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );

endmodule
